FILE: sv/pcbid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the cut-based photon identification block.
// Holds the eta binning, effective areas and working point cut tables; no dependencies.
package pcbid_pkg;

  // Working point codes
  localparam logic [1:0] WP_LOOSE  = 2'd0;
  localparam logic [1:0] WP_MEDIUM = 2'd1;
  localparam logic [1:0] WP_TIGHT  = 2'd2;

  // Barrel/endcap boundary and upper edges of the first six |eta| bins (units of 0.001)
  localparam logic [13:0] EDGE_BARREL = 14'd1479;
  localparam logic [13:0] BIN_EDGE [6] = '{14'd1000, 14'd1479, 14'd2000,
                                            14'd2200, 14'd2300, 14'd2400};

  // Scale of a raw isolation into units of 0.1 keV, and of the neutral compare
  localparam logic [13:0] ISO_SCALE = 14'd10000;
  localparam logic [16:0] NEU_SCALE = 17'd100000;

  // Pt coefficients of the neutral (linear, quadratic) and photon limits
  localparam logic [24:0] NEU_K1_BARREL = 25'd14800000;
  localparam logic [24:0] NEU_K1_ENDCAP = 25'd16300000;
  localparam logic [4:0]  NEU_K2_BARREL = 5'd17;
  localparam logic [4:0]  NEU_K2_ENDCAP = 5'd14;
  localparam logic [5:0]  PHO_K_BARREL  = 6'd47;
  localparam logic [5:0]  PHO_K_ENDCAP  = 6'd34;

  // Effective areas of one eta bin, units of 0.0001
  typedef struct packed {
    logic [10:0] ch;
    logic [10:0] ne;
    logic [10:0] ph;
  } area_t;

  // Cut set with the isolation terms already scaled
  typedef struct packed {
    logic [9:0]  hoe;
    logic [11:0] sieie;
    logic [24:0] ch_lim;   // charged cut * 1e4
    logic [43:0] neu_c;    // neutral constant term * 1e9
    logic [26:0] pho_c;    // photon constant term * 1e4
  } cut_t;

  function automatic area_t area_lookup(logic [2:0] bin);
    area_t a;
    unique case (bin)
      3'd0:    a = '{ch: 11'd360, ne: 11'd597, ph: 11'd1210};
      3'd1:    a = '{ch: 11'd377, ne: 11'd807, ph: 11'd1107};
      3'd2:    a = '{ch: 11'd306, ne: 11'd629, ph: 11'd699};
      3'd3:    a = '{ch: 11'd283, ne: 11'd197, ph: 11'd1056};
      3'd4:    a = '{ch: 11'd254, ne: 11'd184, ph: 11'd1457};
      3'd5:    a = '{ch: 11'd217, ne: 11'd284, ph: 11'd1719};
      default: a = '{ch: 11'd167, ne: 11'd591, ph: 11'd1998};
    endcase
    return a;
  endfunction

  function automatic cut_t make_cut(longint hoe, longint sie, longint ch,
                                    longint neu, longint pho);
    cut_t c;
    c.hoe    = 10'(hoe);
    c.sieie  = 12'(sie);
    c.ch_lim = 25'(ch * 64'd10000);
    c.neu_c  = 44'(neu * 64'd1000000000);
    c.pho_c  = 27'(pho * 64'd10000);
    return c;
  endfunction

  // Unused code three falls into the tight arm
  function automatic cut_t cut_lookup(logic [1:0] wp, logic endcap);
    cut_t c;
    unique case (wp)
      WP_LOOSE:  c = endcap ? make_cut(481, 3013, 1011, 5931, 6641)
                            : make_cut(597, 1031, 1295, 10910, 3630);
      WP_MEDIUM: c = endcap ? make_cut(219, 3001, 442, 1715, 3863)
                            : make_cut(396, 1022, 441, 2725, 2571);
      default:   c = endcap ? make_cut(213, 3000, 34, 586, 2617)
                            : make_cut(269, 994, 202, 264, 2362);
    endcase
    return c;
  endfunction

endpackage

FILE: sv/photon_cut_based_id.sv
`timescale 1ns / 1ps
// Top level of the cut-based photon identification pipeline.
// Depends on pcbid_pkg for the bin, area and cut tables.

// One candidate is taken in every clock cycle (busy never rises) and its
// pass flag appears on out_passed with out_valid after the transfer has
// passed five register stages: eta binning and cut lookup,
// the pileup and pt multipliers, isolation correction and the quadratic pt
// term, limit sums and partial compares, and the final neutral compare.
// Results cannot be held off, so each strobe must be taken when shown.
// The working point is sampled by the first stage; change it only while idle.
module photon_cut_based_id (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [13:0] in_super_cluster_eta,
  input  logic [22:0]        in_transverse_momentum,
  input  logic [19:0]        in_hadronic_over_em,
  input  logic [16:0]        in_shower_width,
  input  logic [19:0]        in_charged_isolation,
  input  logic [19:0]        in_neutral_isolation,
  input  logic [19:0]        in_photon_isolation,
  input  logic [17:0]        in_pileup_density,
  output logic               out_valid,
  output logic               out_passed
);

  logic [1:0] wp_r;

  // Stage 1 registers
  logic                s1_valid_r, s1_shape_ok_r, s1_endcap_r;
  logic [22:0]         s1_pt_r;
  logic [19:0]         s1_chi_r, s1_nei_r, s1_phi_r;
  logic [17:0]         s1_rho_r;
  pcbid_pkg::area_t    s1_area_r;
  pcbid_pkg::cut_t     s1_cut_r;

  // Stage 2 registers
  logic                s2_valid_r, s2_shape_ok_r, s2_endcap_r;
  logic [33:0]         s2_ach_r, s2_ane_r, s2_aph_r;
  logic [28:0]         s2_bch_r, s2_bne_r, s2_bph_r;
  logic [45:0]         s2_pt_sq_r;
  logic [47:0]         s2_pt_k1_r;
  logic [28:0]         s2_pho_k_r;
  pcbid_pkg::cut_t     s2_cut_r;

  // Stage 3 registers
  logic                s3_valid_r, s3_shape_ok_r;
  logic [33:0]         s3_ch_r, s3_ne_r, s3_ph_r;
  logic [50:0]         s3_k2_term_r;
  logic [47:0]         s3_pt_k1_r;
  logic [28:0]         s3_pho_k_r;
  pcbid_pkg::cut_t     s3_cut_r;

  // Stage 4 registers
  logic                s4_valid_r, s4_ok_r;
  logic [50:0]         s4_ne_sc_r;
  logic [51:0]         s4_neu_lim_r;

  // Output registers
  logic                out_valid_r, out_passed_r;

  // Stage 1 next values
  logic                s1_accept;
  logic [13:0]         s1_aeta_nxt;
  logic [2:0]          s1_bin_nxt;
  logic                s1_endcap_nxt;
  logic [1:0]          s1_wp_nxt;
  pcbid_pkg::cut_t     s1_cut_nxt;

  assign busy      = 1'b0;
  assign s1_accept = start & ~busy;

  // Hold the working point register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= pcbid_pkg::WP_LOOSE;
    end else if (cfg_we) begin
      wp_r <= cfg_data;
    end
  end

  // Fold eta to |eta|, pick the bin and the cut set
  always_comb begin
    s1_aeta_nxt = in_super_cluster_eta[13] ? (~in_super_cluster_eta + 14'd1)
                                           : in_super_cluster_eta;
    s1_bin_nxt  = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (s1_aeta_nxt >= pcbid_pkg::BIN_EDGE[i]) begin
        s1_bin_nxt = 3'(i + 1);
      end
    end
    s1_endcap_nxt = s1_aeta_nxt > pcbid_pkg::EDGE_BARREL;
    s1_wp_nxt     = (wp_r == pcbid_pkg::WP_MEDIUM) ? pcbid_pkg::WP_MEDIUM :
                    (wp_r == pcbid_pkg::WP_LOOSE)  ? pcbid_pkg::WP_LOOSE  :
                                                     pcbid_pkg::WP_TIGHT;
    s1_cut_nxt    = pcbid_pkg::cut_lookup(s1_wp_nxt, s1_endcap_nxt);
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // Stage 1: capture the candidate with its areas, cuts and shape compares
  always_ff @(posedge clk) begin
    s1_endcap_r   <= s1_endcap_nxt;
    s1_shape_ok_r <= (in_hadronic_over_em <= 20'(s1_cut_nxt.hoe)) &&
                     (in_shower_width <= 17'(s1_cut_nxt.sieie));
    s1_pt_r       <= in_transverse_momentum;
    s1_chi_r      <= in_charged_isolation;
    s1_nei_r      <= in_neutral_isolation;
    s1_phi_r      <= in_photon_isolation;
    s1_rho_r      <= in_pileup_density;
    s1_area_r     <= pcbid_pkg::area_lookup(s1_bin_nxt);
    s1_cut_r      <= s1_cut_nxt;
  end

  // Stage 2: scale isolations, pileup products and pt terms
  always_ff @(posedge clk) begin
    s2_shape_ok_r <= s1_shape_ok_r;
    s2_endcap_r   <= s1_endcap_r;
    s2_cut_r      <= s1_cut_r;
    s2_ach_r      <= 34'(s1_chi_r) * 34'(pcbid_pkg::ISO_SCALE);
    s2_ane_r      <= 34'(s1_nei_r) * 34'(pcbid_pkg::ISO_SCALE);
    s2_aph_r      <= 34'(s1_phi_r) * 34'(pcbid_pkg::ISO_SCALE);
    s2_bch_r      <= 29'(s1_rho_r) * 29'(s1_area_r.ch);
    s2_bne_r      <= 29'(s1_rho_r) * 29'(s1_area_r.ne);
    s2_bph_r      <= 29'(s1_rho_r) * 29'(s1_area_r.ph);
    s2_pt_sq_r    <= 46'(s1_pt_r) * 46'(s1_pt_r);
    s2_pt_k1_r    <= 48'(s1_pt_r) * 48'(s1_endcap_r ? pcbid_pkg::NEU_K1_ENDCAP
                                                    : pcbid_pkg::NEU_K1_BARREL);
    s2_pho_k_r    <= 29'(s1_pt_r) * 29'(s1_endcap_r ? pcbid_pkg::PHO_K_ENDCAP
                                                    : pcbid_pkg::PHO_K_BARREL);
  end

  // Stage 3: subtract pileup with a floor at zero, weight the pt square
  always_ff @(posedge clk) begin
    s3_shape_ok_r <= s2_shape_ok_r;
    s3_cut_r      <= s2_cut_r;
    s3_pt_k1_r    <= s2_pt_k1_r;
    s3_pho_k_r    <= s2_pho_k_r;
    s3_ch_r       <= (s2_ach_r > 34'(s2_bch_r)) ? (s2_ach_r - 34'(s2_bch_r)) : 34'd0;
    s3_ne_r       <= (s2_ane_r > 34'(s2_bne_r)) ? (s2_ane_r - 34'(s2_bne_r)) : 34'd0;
    s3_ph_r       <= (s2_aph_r > 34'(s2_bph_r)) ? (s2_aph_r - 34'(s2_bph_r)) : 34'd0;
    s3_k2_term_r  <= 51'(s2_pt_sq_r) * 51'(s2_endcap_r ? pcbid_pkg::NEU_K2_ENDCAP
                                                       : pcbid_pkg::NEU_K2_BARREL);
  end

  // Stage 4: charged and photon compares, build the neutral limit
  always_ff @(posedge clk) begin
    s4_ok_r      <= s3_shape_ok_r &&
                    (s3_ch_r <= 34'(s3_cut_r.ch_lim)) &&
                    (s3_ph_r <= (34'(s3_cut_r.pho_c) + 34'(s3_pho_k_r)));
    s4_ne_sc_r   <= 51'(s3_ne_r) * 51'(pcbid_pkg::NEU_SCALE);
    s4_neu_lim_r <= 52'(s3_cut_r.neu_c) + 52'(s3_pt_k1_r) + 52'(s3_k2_term_r);
  end

  // Output: final neutral compare
  always_ff @(posedge clk) begin
    out_passed_r <= s4_ok_r && (52'(s4_ne_sc_r) <= s4_neu_lim_r);
  end

  assign out_valid  = out_valid_r;
  assign out_passed = out_passed_r;

endmodule

FILE: sv/pcbid_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the photon identification block, bound to its top level.
// Depends only on the ports of photon_cut_based_id.
module pcbid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [19:0] in_hadronic_over_em,
  input logic [16:0] in_shower_width,
  input logic        out_valid,
  input logic        out_passed
);

  // Every transfer gives its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result strobe missing five cycles after a transfer");

  // No strobe without a matching earlier transfer
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##5 !out_valid)
    else $error("result strobe without a matching transfer");

  // H/E above the loosest cut of any working point always fails
  a_hoe_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_hadronic_over_em > 20'd597)) |-> ##5 !out_passed)
    else $error("candidate with excessive H/E passed");

  // Shower width above the loosest cut always fails
  a_sie_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_shower_width > 17'd3013)) |-> ##5 !out_passed)
    else $error("candidate with excessive shower width passed");

endmodule

bind photon_cut_based_id pcbid_checker u_pcbid_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_hadronic_over_em (in_hadronic_over_em),
  .in_shower_width     (in_shower_width),
  .out_valid           (out_valid),
  .out_passed          (out_passed)
);
